@@ src/glm_pkg.sv @@
// ---------------------------------------------------------------------------
// glm_pkg
// Shared types and constants of the gradient local-minimum mask block.
// ---------------------------------------------------------------------------
package glm_pkg;

  localparam int PIX_W          = 8;
  localparam int DIM_W          = 12;
  localparam int ROW_W          = 13;
  localparam int GRAD_W         = 21;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int TICK_DEPTH     = 4;
  localparam int OUT_DEPTH      = 16;
  localparam int BACK_STAGES    = 6;

  localparam logic [DIM_W-1:0] DEF_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] DEF_HEIGHT = 12'd480;

  // item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // channel selects
  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  // one classified tick handed from front to back
  typedef struct packed {
    pix_t             pix;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] col2;
    logic             c_is0;
    logic             c_is1;
    logic             top_refl;
    logic             bot_refl;
    logic             s2en;
    logic             c2_is0;
    logic             c2_is1;
    logic             top_ok2;
    logic             bot_ok2;
    logic             mval;
    logic             last;
  } tick_t;

  typedef struct packed {
    logic keep;
    logic frame_last;
  } result_t;

endpackage

@@ src/glm_fifo.sv @@
// ---------------------------------------------------------------------------
// glm_fifo
// Small synchronous queue with occupancy count.
// ---------------------------------------------------------------------------
module glm_fifo #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic [CW-1:0]    count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (!push_ok && pop_ok) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/glm_front.sv @@
// ---------------------------------------------------------------------------
// glm_front
// Tracks the raster position and classifies each accepted word into a tick.
// ---------------------------------------------------------------------------
module glm_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       command,
  input  glm_pkg::pix_t              pix,
  input  logic [glm_pkg::DIM_W-1:0]  cfg_width,
  input  logic [glm_pkg::DIM_W-1:0]  cfg_height,
  input  logic                       restart,
  output logic                       tick_push,
  output glm_pkg::tick_t             tick
);

  import glm_pkg::*;

  logic [DIM_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic [ROW_W-1:0] hx;
  logic [ROW_W-1:0] row2;
  logic [DIM_W-1:0] col2;
  logic             in_frame;
  logic             s2en;
  logic             lower_ok;
  logic             upper_ok;
  logic             last;

  // clamp the dimensions
  always_comb begin
    if (cfg_width < 12'd2) begin
      w = 12'd2;
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      w = DIM_W'(MAX_WIDTH);
    end else begin
      w = cfg_width;
    end
    if (cfg_height < 12'd2) begin
      h = 12'd2;
    end else if (int'(cfg_height) > MAX_HEIGHT) begin
      h = DIM_W'(MAX_HEIGHT);
    end else begin
      h = cfg_height;
    end
  end

  // classify the tick at the current position
  always_comb begin
    hx       = {1'b0, h};
    in_frame = (row < hx);
    s2en     = (row >= 13'd2) || ((row == 13'd1) && (col != '0));
    lower_ok = (row >= 13'd3) || ((row == 13'd2) && (col >= 12'd2));
    upper_ok = (row < hx + 13'd2) || ((row == hx + 13'd2) && (col < 12'd2));
    last     = (row == hx + 13'd2) && (col == 12'd1);
    col2     = (col == '0) ? w - 12'd1 : col - 12'd1;
    row2     = (col == '0) ? row - 13'd2 : row - 13'd1;

    tick.pix      = pix;
    tick.col      = col;
    tick.col2     = col2;
    tick.c_is0    = (col == '0);
    tick.c_is1    = (col == 12'd1);
    tick.top_refl = (row == 13'd1);
    tick.bot_refl = (row == hx);
    tick.s2en     = s2en;
    tick.c2_is0   = (col == 12'd1);
    tick.c2_is1   = (col2 == 12'd1);
    tick.top_ok2  = (row2 >= 13'd2);
    tick.bot_ok2  = (row2 < hx);
    tick.mval     = lower_ok && upper_ok;
    tick.last     = last;

    // flush before the frame is complete is dropped
    tick_push = accept && !(in_frame && (command == CMD_FLUSH));
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (tick_push) begin
      if (last) begin
        col <= '0;
        row <= '0;
      end else if (col == w - 12'd1) begin
        col <= '0;
        row <= row + 13'd1;
      end else begin
        col <= col + 12'd1;
      end
    end
  end

endmodule

@@ src/glm_back.sv @@
// ---------------------------------------------------------------------------
// glm_back
// Sobel gradient pipeline and 3x3 local-minimum compare over row buffers.
// ---------------------------------------------------------------------------
module glm_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int OUT_DEPTH = 16,
  localparam int OCW = $clog2(OUT_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  glm_pkg::tick_t    tick,
  input  logic              tick_valid,
  output logic              tick_pop,
  input  logic [OCW-1:0]    out_count,
  output logic              out_push,
  output glm_pkg::result_t  out_word
);

  import glm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int IW = $clog2(BACK_STAGES + 1);

  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } pcol_t;

  typedef struct packed {
    pix_t upper;
    pix_t lower;
  } ppair_t;

  typedef struct packed {
    logic [GRAD_W-1:0] top;
    logic [GRAD_W-1:0] mid;
    logic [GRAD_W-1:0] bot;
  } gcol_t;

  typedef struct packed {
    logic [GRAD_W-1:0] upper;
    logic [GRAD_W-1:0] lower;
  } gpair_t;

  function automatic logic [PIX_W-1:0] chan(pix_t p, logic [1:0] k);
    logic [PIX_W-1:0] v;
    case (k)
      CH_BLUE:  v = p.blue;
      CH_GREEN: v = p.green;
      default:  v = p.red;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] sum121(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  // row buffers
  ppair_t pmem [MAX_WIDTH];
  gpair_t gmem [MAX_WIDTH];

  logic [IW-1:0]          inflight;
  logic                   issue;
  logic                   v1, v2, v3, v4, v5, v6;
  tick_t                  t1, t2, t3, t4, t5, t6;
  logic [DIM_W+AW-1:0]    ext0, ext1, ext4, ext5;
  ppair_t                 rd_pix;
  gpair_t                 rd_grad;
  pcol_t                  pcol;
  pcol_t                  pwa, pwb;
  pcol_t                  lcol, rcol;
  pcol_t                  lc2, cc2, rc2;
  logic signed [10:0]     gx2 [3];
  logic signed [10:0]     gy2 [3];
  logic signed [10:0]     gx3 [3];
  logic signed [10:0]     gy3 [3];
  logic [GRAD_W-1:0]      sq3 [3];
  logic [GRAD_W-1:0]      sq4 [3];
  logic [GRAD_W-1:0]      gmax4;
  logic [GRAD_W-1:0]      g5;
  gcol_t                  gcol;
  gcol_t                  gwa, gwb;
  logic                   fwb_top, fwb_bot;
  logic                   keep5;
  logic                   keep6;

  // issue only when the output queue has room for every tick in flight
  assign issue    = tick_valid && ((int'(out_count) + int'(inflight)) < OUT_DEPTH);
  assign tick_pop = issue;

  assign ext0 = {{AW{1'b0}}, tick.col};
  assign ext1 = {{AW{1'b0}}, t1.col};
  assign ext4 = {{AW{1'b0}}, t4.col2};
  assign ext5 = {{AW{1'b0}}, t5.col2};

  // valid pipeline and in-flight count
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      inflight <= '0;
    end else begin
      v1 <= issue; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
      if (issue && !v6) begin
        inflight <= inflight + 1'b1;
      end else if (!issue && v6) begin
        inflight <= inflight - 1'b1;
      end
    end
  end

  // tick payload through the stages
  always_ff @(posedge clk) begin
    t1 <= tick; t2 <= t1; t3 <= t2;
    t4 <= t3; t5 <= t4; t6 <= t5;
  end

  // pixel row buffer read
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_pix <= pmem[ext0[AW-1:0]];
    end
  end

  // pixel column with reflected rows, window taps
  always_comb begin
    pcol.mid = rd_pix.lower;
    pcol.top = t1.top_refl ? t1.pix : rd_pix.upper;
    pcol.bot = t1.bot_refl ? rd_pix.upper : t1.pix;
    lcol     = t1.c_is1 ? pcol : pwa;
    rcol     = t1.c_is0 ? pwa : pcol;
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      pmem[ext1[AW-1:0]] <= '{upper: rd_pix.lower, lower: t1.pix};
      pwa <= pwb;
      pwb <= pcol;
    end
    lc2 <= lcol;
    cc2 <= pwb;
    rc2 <= rcol;
  end

  // sobel derivatives per channel
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gx2[k] = $signed({1'b0, sum121(chan(rc2.top, 2'(k)), chan(rc2.mid, 2'(k)),
                                     chan(rc2.bot, 2'(k)))})
             - $signed({1'b0, sum121(chan(lc2.top, 2'(k)), chan(lc2.mid, 2'(k)),
                                     chan(lc2.bot, 2'(k)))});
      gy2[k] = $signed({1'b0, sum121(chan(lc2.bot, 2'(k)), chan(cc2.bot, 2'(k)),
                                     chan(rc2.bot, 2'(k)))})
             - $signed({1'b0, sum121(chan(lc2.top, 2'(k)), chan(cc2.top, 2'(k)),
                                     chan(rc2.top, 2'(k)))});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      gx3[k] <= gx2[k];
      gy3[k] <= gy2[k];
    end
  end

  // squared magnitude per channel
  always_comb begin
    logic signed [21:0] px;
    logic signed [21:0] py;
    for (int k = 0; k < 3; k++) begin
      px     = gx3[k] * gx3[k];
      py     = gy3[k] * gy3[k];
      sq3[k] = GRAD_W'(px[19:0]) + GRAD_W'(py[19:0]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq4[k] <= sq3[k];
    end
  end

  // maximum over channels
  always_comb begin
    gmax4 = sq4[0];
    if (sq4[1] > gmax4) begin
      gmax4 = sq4[1];
    end
    if (sq4[2] > gmax4) begin
      gmax4 = sq4[2];
    end
  end

  // gradient row buffer read alongside the max
  always_ff @(posedge clk) begin
    g5 <= gmax4;
    if (v4) begin
      rd_grad <= gmem[ext4[AW-1:0]];
    end
  end

  // local minimum over existing neighbors
  always_comb begin
    logic [GRAD_W-1:0] own;
    logic              lok;
    logic              rok;
    gcol.top = rd_grad.upper;
    gcol.mid = rd_grad.lower;
    gcol.bot = g5;
    own      = gwb.mid;
    lok      = !t5.c2_is1;
    rok      = !t5.c2_is0;
    keep5 = !(lok && (gwa.mid < own))
         && !(lok && fwb_top && (gwa.top < own))
         && !(lok && fwb_bot && (gwa.bot < own))
         && !(fwb_top && (gwb.top < own))
         && !(fwb_bot && (gwb.bot < own))
         && !(rok && (gcol.mid < own))
         && !(rok && fwb_top && (gcol.top < own))
         && !(rok && fwb_bot && (gcol.bot < own));
  end

  always_ff @(posedge clk) begin
    if (v5 && t5.s2en) begin
      gmem[ext5[AW-1:0]] <= '{upper: rd_grad.lower, lower: g5};
      gwa     <= gwb;
      gwb     <= gcol;
      fwb_top <= t5.top_ok2;
      fwb_bot <= t5.bot_ok2;
    end
    keep6 <= keep5;
  end

  // result word
  assign out_push            = v6 && t6.mval;
  assign out_word.keep       = keep6;
  assign out_word.frame_last = t6.last;

endmodule

@@ src/gradient_local_min_mask.sv @@
// ---------------------------------------------------------------------------
// gradient_local_min_mask
// Sobel gradient magnitude local-minimum mask over a raster BGR stream.
// ---------------------------------------------------------------------------
// Pixels enter in raster order, one word per clock sustained while full is
// low, through a queue-style push/full port; mask bits leave in raster order
// through an empty/pop port, the frame's final bit flagged by frame_last.
// Each accepted word is classified up front and handed through a four-entry
// queue to a six-stage back end (pixel row buffer, Sobel sums, squares,
// channel max, gradient row buffer, 3x3 compare). A mask bit is produced
// 2*width+2 ticks after its pixel, so after the frame's last pixel 2*width+2
// flush words drain it; flush words sent before the frame is full are
// dropped. The back end issues a word only when the 16-entry result queue
// can take everything in flight, so a stalled reader backs up into full.
// Writing width or height (APB, byte addresses 0 and 4) restarts the frame;
// the user must have it done only while the block is idle, which the block
// itself does not enforce.
// ---------------------------------------------------------------------------
module gradient_local_min_mask #(
  parameter int MAX_WIDTH  = glm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = glm_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  output logic        empty,
  input  logic        pop,
  output logic        keep,
  output logic        frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import glm_pkg::*;

  localparam int TCW = $clog2(TICK_DEPTH + 1);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             cfg_wr;
  logic             accept;
  pix_t             pix;
  logic             tick_push;
  tick_t            tick_in;
  tick_t            tick_out;
  logic             tick_empty;
  logic             tick_pop;
  logic [TCW-1:0]   tick_count;
  logic             out_push;
  result_t          out_word;
  result_t          out_head;
  logic             out_full;
  logic [OCW-1:0]   out_count;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DEF_WIDTH;
      image_height <= DEF_HEIGHT;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        image_width <= pwdata[DIM_W-1:0];
      end else begin
        image_height <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {20'd0, image_height} : {20'd0, image_width};

  // input side
  assign accept    = push && !full;
  assign pix.blue  = blue;
  assign pix.green = green;
  assign pix.red   = red;

  glm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (command),
    .pix        (pix),
    .cfg_width  (image_width),
    .cfg_height (image_height),
    .restart    (cfg_wr),
    .tick_push  (tick_push),
    .tick       (tick_in)
  );

  // queue between front and back
  glm_fifo #(
    .WIDTH ($bits(tick_t)),
    .DEPTH (TICK_DEPTH)
  ) u_tick_q (
    .clk   (clk),
    .rst   (rst),
    .push  (tick_push),
    .din   (tick_in),
    .full  (full),
    .pop   (tick_pop),
    .dout  (tick_out),
    .empty (tick_empty),
    .count (tick_count)
  );

  glm_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick_out),
    .tick_valid (!tick_empty && (tick_count != '0)),
    .tick_pop   (tick_pop),
    .out_count  (out_count),
    .out_push   (out_push),
    .out_word   (out_word)
  );

  // result queue
  glm_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_word),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_head),
    .empty (empty),
    .count (out_count)
  );

  assign keep       = out_head.keep && !out_full | out_head.keep;
  assign frame_last = out_head.frame_last;

endmodule

@@ src/glm_checker.sv @@
// ---------------------------------------------------------------------------
// glm_checker
// Port-level checks of the gradient local-minimum mask block.
// ---------------------------------------------------------------------------
module glm_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        keep,
  input logic        frame_last,
  input logic        psel,
  input logic        pwrite,
  input logic [31:0] prdata,
  input logic        pready
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a waiting word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(keep) && $stable(frame_last)))
    else $error("waiting result changed");

  // full only rises after an input word was taken
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without an input word");

  // dimension registers read back as 12-bit values
  a_read_width: assert property (@(posedge clk) disable iff (rst)
    (psel && !pwrite && pready) |-> (prdata[31:12] == 20'd0))
    else $error("register read has upper bits set");

endmodule

bind gradient_local_min_mask glm_checker u_glm_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .keep       (keep),
  .frame_last (frame_last),
  .psel       (psel),
  .pwrite     (pwrite),
  .prdata     (prdata),
  .pready     (pready)
);

@@ tb/tb_gradient_local_min_mask.sv @@
// ---------------------------------------------------------------------------
// tb_gradient_local_min_mask
// Self-checking bench for the Sobel gradient local-minimum mask block.
// ---------------------------------------------------------------------------
// A predictor keeps its own pixel and gradient row rings and frame position.
// For every accepted word it works out the mask bit that falls due, if any.
// A checker compares each popped mask bit and frame_last flag with the
// oldest prediction. The stimulus covers frames of many small sizes, clamped
// register values, early flush words, pixels sent after the
// frame's last pixel, and abandoned frames. The sender idles in bursts and
// the reader stalls on changing patterns.
// ---------------------------------------------------------------------------
module tb_gradient_local_min_mask;
  timeunit 1ns;
  timeprecision 1ps;
  import glm_pkg::*;

  localparam int RING_LEN   = 2 * 2048 + 4;
  localparam int RAND_WORDS = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        command = CMD_PIXEL;
  logic [7:0]  blue = '0;
  logic [7:0]  green = '0;
  logic [7:0]  red = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        keep;
  logic        frame_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gradient_local_min_mask uut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [23:0]       pix_ring  [RING_LEN];
  logic [GRAD_W-1:0] grad_ring [RING_LEN];
  logic [DIM_W-1:0]  width_reg = DEF_WIDTH;
  logic [DIM_W-1:0]  height_reg = DEF_HEIGHT;
  int                frame_pos = 0;
  result_t           mask_expect[$];

  // run statistics
  int words_sent = 0;
  int bits_seen = 0;
  int keeps_seen = 0;
  int frames_done = 0;
  int mismatches = 0;

  // sender idling
  int burst_left = 0;
  bit no_gaps = 1'b0;

  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v < 2) return 2;
    if (v > 2048) return 2048;
    return int'(v);
  endfunction

  function automatic int refl(int i, int n);
    if (i < 0) return 1;
    if (i >= n) return n - 2;
    return i;
  endfunction

  function automatic int chan(int r, int c, int w, int ch);
    logic [23:0] p;
    p = pix_ring[(r * w + c) % RING_LEN];
    return int'((p >> (8 * ch)) & 24'hff);
  endfunction

  // max over channels of gx^2 + gy^2
  function automatic int sobel_energy(int q, int w, int h);
    int wt[3];
    int rows[3];
    int cols[3];
    int best, gx, gy, v;
    wt = '{1, 2, 1};
    best = 0;
    for (int i = 0; i < 3; i++) begin
      rows[i] = refl(q / w + i - 1, h);
      cols[i] = refl(q % w + i - 1, w);
    end
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
        gx += wt[i] * (chan(rows[i], cols[2], w, ch) - chan(rows[i], cols[0], w, ch));
        gy += wt[i] * (chan(rows[2], cols[i], w, ch) - chan(rows[0], cols[i], w, ch));
      end
      v = gx * gx + gy * gy;
      if (v > best) best = v;
    end
    return best;
  endfunction

  function automatic logic is_local_min(int m, int w, int h);
    int r, c, rr, cc;
    logic [GRAD_W-1:0] own;
    r = m / w;
    c = m % w;
    own = grad_ring[m % RING_LEN];
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if (!(dr == 0 && dc == 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
          if (grad_ring[(rr * w + cc) % RING_LEN] < own) return 1'b0;
      end
    return 1'b1;
  endfunction

  // advance the predictor by one accepted word
  function automatic void predict_tick(logic cmd, logic [7:0] b, logic [7:0] g,
                                       logic [7:0] r);
    int w, h, total, lag, m;
    result_t res;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    total = w * h;
    lag = w + 1;
    if (frame_pos < total) begin
      if (cmd == CMD_FLUSH) return;
      pix_ring[frame_pos % RING_LEN] = {r, g, b};
    end
    if (frame_pos >= lag && frame_pos - lag < total)
      grad_ring[(frame_pos - lag) % RING_LEN] =
        GRAD_W'(sobel_energy(frame_pos - lag, w, h));
    if (frame_pos >= 2 * lag && frame_pos - 2 * lag < total) begin
      m = frame_pos - 2 * lag;
      res.keep = is_local_min(m, w, h);
      res.frame_last = (m == total - 1);
      mask_expect.push_back(res);
      if (res.frame_last) begin
        frame_pos = 0;
        return;
      end
    end
    frame_pos++;
  endfunction

  // send one word, honoring the burst/gap pattern
  task automatic send_word(logic cmd, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = no_gaps ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                        : $urandom_range(0, 4));
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push    <= 1'b1;
    command <= cmd;
    blue    <= b;
    green   <= g;
    red     <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_tick(cmd, b, g, r);
    words_sent++;
  endtask

  task automatic send_pixel(logic [23:0] bgr);
    send_word(CMD_PIXEL, bgr[7:0], bgr[15:8], bgr[23:16]);
  endtask

  task automatic send_flush();
    send_word(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // stop sending and wait until every predicted word has been popped
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (mask_expect.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic reg_write(logic idx, logic [DIM_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) width_reg = value;
    else height_reg = value;
    frame_pos = 0;
  endtask

  task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    wait_idle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  function automatic logic [23:0] pick_pixel(int style, int idx);
    case (style)
      0: return 24'($urandom);
      1: return 24'h5a3c81;
      2: return $urandom_range(0, 1) ? 24'hffffff : 24'h000000;
      default: return {3{8'((idx * 7) & 8'hff)}} ^ 24'($urandom_range(0, 3));
    endcase
  endfunction

  // one full frame: pixels with stray early flushes, then the drain ticks
  task automatic send_frame(int style, int noise_pct);
    int w, h;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_flush();
      send_pixel(pick_pixel(style, i));
    end
    // pixels past the frame's end act as flush ticks
    for (int i = 0; i < 2 * w + 2; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_pixel(24'($urandom));
      else send_flush();
    end
    frames_done++;
  endtask

  // mask bit checker and reader stall pattern
  int pop_mode = 0;
  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst && pop && !empty) begin
      bits_seen++;
      if (keep) keeps_seen++;
      if (mask_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mask word with none expected: keep=%0b frame_last=%0b", keep, frame_last);
      end else begin
        if (keep !== mask_expect[0].keep || frame_last !== mask_expect[0].frame_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mask word %0d: expected keep=%0b last=%0b, got keep=%0b last=%0b",
                     bits_seen, mask_expect[0].keep, mask_expect[0].frame_last,
                     keep, frame_last);
        end
        void'(mask_expect.pop_front());
      end
    end
    if (cyc % 128 == 0) pop_mode = $urandom_range(0, 3);
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom);
      2: pop <= ($urandom_range(0, 5) == 0);
      default: pop <= (cyc % 32) < 24;
    endcase
  end

  // directed: smallest frame, extreme values, early flushes
  task automatic test_smallest_frame();
    set_dims(12'd2, 12'd2);
    send_flush();
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_flush();
    send_pixel(24'hff00ff);
    send_pixel(24'h00ff00);
    // drain with a stray pixel among the flush ticks
    send_flush();
    send_pixel(24'h123456);
    send_flush();
    send_flush();
    send_flush();
    send_flush();
    frames_done++;
  endtask

  // directed: out-of-range register values clamp to 2
  task automatic test_clamped_low();
    set_dims(12'd0, 12'd1);
    send_frame(2, 0);
    set_dims(12'd1, 12'd3);
    send_frame(0, 0);
  endtask

  // directed: flat frame keeps everything
  task automatic test_flat_frame();
    set_dims(12'd3, 12'd3);
    send_frame(1, 0);
  endtask

  // directed: wide and tall frames
  task automatic test_extreme_dims();
    set_dims(12'd64, 12'd2);
    send_frame(3, 0);
    set_dims(12'd2, 12'd64);
    send_frame(0, 0);
  endtask

  // random frames, abandoned frames and pauses
  task automatic test_random_frames();
    int start, cut;
    start = words_sent;
    while (words_sent - start < RAND_WORDS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 4 || frames_done < 8)
        set_dims(12'($urandom_range(2, 16)), 12'($urandom_range(2, 10)));
      if ($urandom_range(0, 11) == 0) begin
        // broken frame: stop partway and restart by a register write
        cut = $urandom_range(1, eff_dim(width_reg) * eff_dim(height_reg) + 6);
        for (int i = 0; i < cut; i++) send_pixel(24'($urandom));
        set_dims(width_reg, height_reg);
      end else begin
        send_frame($urandom_range(0, 3), $urandom_range(0, 1) ? 0 : 6);
      end
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_smallest_frame();
    test_clamped_low();
    test_flat_frame();
    test_random_frames();
    test_extreme_dims();
    wait_idle();
    $display("covered %0d frames, %0d words sent, %0d mask bits checked (%0d kept)",
             frames_done, words_sent, bits_seen, keeps_seen);
    $display("sizes from 2x2 up to 64 wide and 64 tall, clamped register values included");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("timeout with %0d mask words outstanding", mask_expect.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
